FILE: src/blm_pkg.sv
package blm_pkg;

    localparam int MaxRows = 16;
    localparam int MaxCols = 16;
    localparam int RowIdxW = $clog2(MaxRows);
    localparam int ColIdxW = $clog2(MaxCols);
    localparam int CellAddrW = RowIdxW + ColIdxW;
    localparam int CntW = 5;
    localparam int CfgIdxW = 1;

    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_ROW_BP = 2'd1;
    localparam logic [1:0] KIND_COL_BP = 2'd2;
    localparam logic [1:0] KIND_CELL   = 2'd3;

    localparam logic [CfgIdxW-1:0] CFG_ROW_COUNT = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_COL_COUNT = 1'd1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] row_coord;
        logic [15:0] col_coord;
        logic [3:0]  row_index;
        logic [3:0]  col_index;
        logic [15:0] axis_data;
        logic signed [15:0] cell_data;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] interp_value;
        logic [3:0]  base_row;
        logic [3:0]  base_col;
        logic [15:0] row_frac;
        logic [15:0] col_frac;
    } t_out_beat;

    typedef struct packed {
        logic        start;
        logic [15:0] num;
        logic [15:0] den;
    } t_div_req;

endpackage

FILE: src/blm_stream_if.sv
interface blm_in_if;
    logic              valid;
    logic              ready;
    blm_pkg::t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface blm_out_if;
    logic               valid;
    logic               ready;
    blm_pkg::t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/blm_div.sv
// restoring divider, one quotient bit a cycle, q = (num << 16) / den, num < den
module blm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  blm_pkg::t_div_req i_req,
    output logic              o_done,
    output logic [15:0]       o_quot
);
    logic [16:0] r_rem;
    logic [15:0] r_den;
    logic [15:0] r_quot;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [17:0] w_trial;

    assign w_trial = {r_rem, 1'b0} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= {1'b0, i_req.num};
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_busy) begin
            if (!w_trial[17]) begin
                r_rem  <= w_trial[16:0];
                r_quot <= {r_quot[14:0], 1'b1};
            end else begin
                r_rem  <= {r_rem[15:0], 1'b0};
                r_quot <= {r_quot[14:0], 1'b0};
            end
        end
    end

    assign o_quot = r_quot;
endmodule

FILE: src/blm_blend.sv
// blend: products registered, then the rounded sum registered
module blm_blend (
    input  logic               i_clk,
    input  logic signed [15:0] i_a,
    input  logic signed [15:0] i_b,
    input  logic [16:0]        i_w,
    output logic signed [15:0] o_res
);
    logic signed [33:0] r_pa;
    logic signed [33:0] r_pb;
    logic signed [34:0] w_sum;
    logic [16:0]        w_wc;

    assign w_wc  = 17'd65536 - i_w;
    assign w_sum = 35'(r_pa) + 35'(r_pb) + 35'sd32768;

    always_ff @(posedge i_clk) begin
        r_pa  <= i_a * $signed({1'b0, w_wc});
        r_pb  <= i_b * $signed({1'b0, i_w});
        o_res <= w_sum[31:16];
    end
endmodule

FILE: src/bilinear_map_lookup.sv
// bilinear calibration map lookup
// input channel: one beat per item; kind selects a lookup, a row or column
// breakpoint write, or a cell write. a write gives no result and leaves the
// block idle, so writes can follow each other back to back.
// output channel: one beat per lookup with the blended value, both base
// indices and both Q0.16 fractions, held in an output register.
// configuration: write enable, index (0 row_count, 1 col_count), data;
// counts are clamped to 2..16 on use.
// a lookup loads the output register after, per axis, three reads for the
// clamp and the end checks, up to four search steps, two reads for the
// bracket and a serial division when the fraction is neither 0 nor one,
// then four cell reads and three blends. the division and the single-port
// reads set how long a lookup takes.
// one item is in work at a time; the input is taken again in the cycle after
// the result is loaded. a stalled receiver holds a finished lookup in its
// last state until the output register is free; writes wait as well.
// reset clears the control and the counts (16); memory contents are
// undefined until written, no clearing pass.
module bilinear_map_lookup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    blm_in_if.sink                        in_ch,
    blm_out_if.source                     out_ch,
    input  logic                          i_cfg_we,
    input  logic [blm_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [blm_pkg::CntW-1:0]      i_cfg_data
);
    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_RDLO  = 14'b00000000000010,
        S_RDHI  = 14'b00000000000100,
        S_SRCH  = 14'b00000000001000,
        S_SRD   = 14'b00000000010000,
        S_BKT   = 14'b00000000100000,
        S_BKD   = 14'b00000001000000,
        S_DIV   = 14'b00000010000000,
        S_DWT   = 14'b00000100000000,
        S_CRD   = 14'b00001000000000,
        S_B1    = 14'b00010000000000,
        S_B2    = 14'b00100000000000,
        S_B3    = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } t_state;

    t_state r_state;
    logic [blm_pkg::CntW-1:0] r_row_cnt, r_col_cnt;
    logic [15:0] row_mem [blm_pkg::MaxRows];
    logic [15:0] col_mem [blm_pkg::MaxCols];
    logic signed [15:0] cell_mem [blm_pkg::MaxRows*blm_pkg::MaxCols];

    logic r_axis;  // 0 row, 1 column
    logic [3:0] r_raddr, r_lo, r_hi, r_base_r, r_base_c, r_n2;
    logic [15:0] r_rd, r_crd, r_x, r_first, r_x0, r_x1;
    logic [16:0] r_wr, r_wc;
    logic [1:0] r_ccnt;
    logic signed [15:0] r_q [4];
    logic signed [15:0] r_v1, r_v2;
    logic [blm_pkg::CellAddrW-1:0] r_caddr;
    logic [1:0] r_stage;
    logic [15:0] r_col_coord;
    blm_pkg::t_out_beat r_out;
    logic r_ovalid;
    blm_pkg::t_div_req w_dreq;
    logic w_ddone;
    logic [15:0] w_dq;
    logic signed [15:0] w_ba, w_bb, w_bres;
    logic [16:0] w_bw;
    logic w_bfinal;
    logic [3:0] w_ncnt, w_mid;
    logic [15:0] w_x;
    logic w_up, w_dn, w_full, w_need_div;

    // counts clamped to 2..16, held as count-1
    function automatic logic [3:0] eff_m1(input logic [4:0] c);
        logic [3:0] r;
        if (c < 5'd2) r = 4'd1;
        else if (c > 5'd16) r = 4'd15;
        else r = 4'(c - 5'd1);
        return r;
    endfunction

    assign w_ncnt = r_axis ? eff_m1(r_col_cnt) : eff_m1(r_row_cnt);
    assign w_mid  = 4'((5'(r_lo) + 5'(r_hi)) >> 1);
    assign w_x    = r_x;

    always_ff @(posedge i_clk) begin
        r_rd  <= r_axis ? col_mem[r_raddr] : row_mem[r_raddr];
        r_crd <= cell_mem[r_caddr];
        if (in_ch.valid && in_ch.ready) begin
            case (in_ch.data.kind)
                blm_pkg::KIND_ROW_BP: row_mem[in_ch.data.row_index] <= in_ch.data.axis_data;
                blm_pkg::KIND_COL_BP: col_mem[in_ch.data.col_index] <= in_ch.data.axis_data;
                blm_pkg::KIND_CELL:
                    cell_mem[{in_ch.data.row_index, in_ch.data.col_index}] <=
                        in_ch.data.cell_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= 5'd16;
            r_col_cnt <= 5'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                blm_pkg::CFG_ROW_COUNT: r_row_cnt <= i_cfg_data;
                blm_pkg::CFG_COL_COUNT: r_col_cnt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ch.ready = (r_state == S_IDLE);
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_out;

    // bracket rising or falling; the weight is one at or past the far end
    assign w_up       = (r_x1 > r_x0) && (r_x > r_x0);
    assign w_dn       = (r_x1 < r_x0) && (r_x < r_x0);
    assign w_full     = w_up ? (r_x >= r_x1) : (r_x <= r_x1);
    assign w_need_div = (w_up || w_dn) && !w_full;

    assign w_dreq.start = (r_state == S_BKD) && (r_stage == 2'd3) && w_need_div;
    assign w_dreq.num   = w_up ? (r_x - r_x0) : (r_x0 - r_x);
    assign w_dreq.den   = w_up ? (r_x1 - r_x0) : (r_x0 - r_x1);

    blm_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_done (w_ddone),
        .o_quot (w_dq)
    );

    // final blend inputs held through the output wait
    assign w_bfinal = (r_state == S_B3) || (r_state == S_OUT);
    assign w_ba = w_bfinal ? r_v1 : ((r_stage[0]) ? r_q[1] : r_q[0]);
    assign w_bb = w_bfinal ? r_v2 : ((r_stage[0]) ? r_q[3] : r_q[2]);
    assign w_bw = w_bfinal ? r_wc : r_wr;

    blm_blend u_blend (
        .i_clk(i_clk),
        .i_a  (w_ba),
        .i_b  (w_bb),
        .i_w  (w_bw),
        .o_res(w_bres)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_ch.valid && in_ch.ready
                        && in_ch.data.kind == blm_pkg::KIND_LOOKUP) begin
                        r_col_coord <= in_ch.data.col_coord;
                        r_axis      <= 1'b0;
                        r_x         <= in_ch.data.row_coord;
                        r_raddr     <= 4'd0;
                        r_state     <= S_RDLO;
                    end
                end
                S_RDLO: begin   // r_rd = axis[0] next
                    r_raddr <= w_ncnt;
                    r_state <= S_RDHI;
                end
                S_RDHI: begin
                    r_first <= r_rd;
                    r_raddr <= 4'(w_ncnt - 4'd1);
                    r_n2    <= 4'(w_ncnt - 4'd1);
                    r_state <= S_SRCH;
                end
                S_SRCH: begin   // r_rd = last; clamp
                    if (w_x < r_first) r_x <= r_first;
                    else if (w_x > r_rd) r_x <= r_rd;
                    r_state <= S_SRD;
                end
                S_SRD: begin
                    // r_rd = axis[n-2]; decide ends, else search
                    if (r_x <= r_first) begin
                        r_lo <= 4'd0;
                        r_hi <= 4'd1;
                    end else if (r_x >= r_rd) begin
                        r_lo <= r_n2;
                        r_hi <= w_ncnt;
                    end else begin
                        r_lo <= 4'd0;
                        r_hi <= w_ncnt;
                    end
                    r_stage <= 2'd0;
                    r_state <= S_BKT;
                end
                S_BKT: begin
                    if (4'(r_hi - r_lo) > 4'd1) begin
                        if (r_stage == 2'd0) begin
                            r_raddr <= w_mid;
                            r_stage <= 2'd1;
                        end else if (r_stage == 2'd1) begin
                            r_stage <= 2'd2;
                        end else begin
                            if (r_x >= r_rd) r_lo <= w_mid;
                            else r_hi <= w_mid;
                            r_stage <= 2'd0;
                        end
                    end else begin
                        r_raddr <= r_lo;
                        r_stage <= 2'd0;
                        r_state <= S_BKD;
                    end
                end
                S_BKD: begin    // fetch x0 then x1
                    r_stage <= r_stage + 2'd1;
                    case (r_stage)
                        2'd0: r_raddr <= r_hi;
                        2'd1: r_x0 <= r_rd;
                        2'd2: r_x1 <= r_rd;
                        default: ;
                    endcase
                    if (r_stage == 2'd3) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // weight: special cases or wait for divider
                    if (!(w_up || w_dn)) begin
                        if (r_axis) r_wc <= 17'd0; else r_wr <= 17'd0;
                        r_state <= S_DWT;
                    end else if (w_full) begin
                        if (r_axis) r_wc <= 17'd65536; else r_wr <= 17'd65536;
                        r_state <= S_DWT;
                    end else if (w_ddone) begin
                        if (r_axis) r_wc <= {1'b0, w_dq}; else r_wr <= {1'b0, w_dq};
                        r_state <= S_DWT;
                    end
                end
                S_DWT: begin
                    if (!r_axis) begin
                        r_base_r <= r_lo;
                        r_axis   <= 1'b1;
                        r_x      <= r_col_coord;
                        r_raddr  <= 4'd0;
                        r_state  <= S_RDLO;
                    end else begin
                        r_base_c <= r_lo;
                        r_ccnt   <= 2'd0;
                        r_stage  <= 2'd0;
                        r_caddr  <= {r_base_r, r_lo};
                        r_state  <= S_CRD;
                    end
                end
                S_CRD: begin    // q order: q11, q12, q21, q22
                    r_stage <= r_stage + 2'd1;
                    case (r_stage)
                        2'd0: r_caddr <= {r_base_r, 4'(r_base_c + 4'd1)};
                        2'd1: r_caddr <= {4'(r_base_r + 4'd1), r_base_c};
                        2'd2: r_caddr <= {4'(r_base_r + 4'd1), 4'(r_base_c + 4'd1)};
                        default: ;
                    endcase
                    if (r_stage != 2'd0) r_q[r_ccnt] <= r_crd;
                    if (r_stage != 2'd0) r_ccnt <= r_ccnt + 2'd1;
                    if (r_stage == 2'd3) begin
                        r_state <= S_B1;
                    end
                end
                S_B1: begin
                    if (r_ccnt == 2'd3) begin
                        r_q[3] <= r_crd;
                        r_ccnt <= 2'd0;
                    end
                    if (r_stage == 2'd2) begin
                        r_state <= S_B2;
                        r_stage <= 2'd1;
                    end else begin
                        r_stage <= r_stage + 2'd1;
                    end
                end
                S_B2: begin
                    // blend results trail their inputs through the product and sum registers
                    r_stage <= r_stage + 2'd1;
                    if (r_stage == 2'd2) r_v1 <= w_bres;
                    if (r_stage == 2'd3) begin
                        r_v2    <= w_bres;
                        r_state <= S_B3;
                    end
                end
                S_B3: begin
                    r_stage <= r_stage + 2'd1;
                    if (r_stage == 2'd2) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_out.interp_value <= w_bres;
                        r_out.base_row     <= r_base_r;
                        r_out.base_col     <= r_base_c;
                        r_out.row_frac     <= r_wr[16] ? 16'hFFFF : r_wr[15:0];
                        r_out.col_frac     <= r_wc[16] ? 16'hFFFF : r_wc[15:0];
                        r_ovalid           <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
